@@ rtl/prord_pkg.sv @@
// shared types and constants of the pin routing order block
package prord_pkg;

   localparam int MAX_PINS_DEF   = 64;
   localparam int COORD_BITS_DEF = 12;
   localparam int PIN_W          = 12;
   localparam int IDX_W          = 6;
   localparam int DIAG_W         = 10;
   localparam logic [DIAG_W-1:0] DIAG_RESET = 10'd362;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAIR,
      ST_PDRAIN,
      ST_EMIT,
      ST_RUN,
      ST_DRAIN
   } state_type;

endpackage

@@ rtl/prord_dist.sv @@
// two stage octile distance unit
module prord_dist import prord_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int DIST_W     = COORD_BITS_DEF + 11
) (
   input  logic                  clock,
   input  logic [COORD_BITS-1:0] a_x,
   input  logic [COORD_BITS-1:0] a_y,
   input  logic [COORD_BITS-1:0] b_x,
   input  logic [COORD_BITS-1:0] b_y,
   input  logic [DIAG_W-1:0]     diag,
   output logic [DIST_W-1:0]     dist_out
);

   logic [COORD_BITS-1:0]        dx, dy;
   logic [COORD_BITS-1:0]        lo_in, span_in;
   logic [COORD_BITS-1:0]        lo_ff, span_ff;
   logic [COORD_BITS+DIAG_W-1:0] prod;
   logic [DIST_W-1:0]            dist_in, dist_ff;

   always_comb begin
      dx = (a_x > b_x) ? a_x - b_x : b_x - a_x;
      dy = (a_y > b_y) ? a_y - b_y : b_y - a_y;
      if (dx < dy) begin
         lo_in   = dx;
         span_in = dy - dx;
      end else begin
         lo_in   = dy;
         span_in = dx - dy;
      end
   end

   assign prod    = (COORD_BITS+DIAG_W)'(lo_ff) * (COORD_BITS+DIAG_W)'(diag);
   assign dist_in = DIST_W'(prod) + (DIST_W'(span_ff) << 8);

   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      span_ff <= span_in;
      dist_ff <= dist_in;
   end

   assign dist_out = dist_ff;

endmodule

@@ rtl/prord_store.sv @@
// pin coordinate memory, one write port and two registered read ports
module prord_store import prord_pkg::*; #(
   parameter int MAX_PINS   = MAX_PINS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int AW         = $clog2(MAX_PINS)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [COORD_BITS-1:0] wr_x,
   input  logic [COORD_BITS-1:0] wr_y,
   input  logic [AW-1:0]         rd_a_addr,
   input  logic [AW-1:0]         rd_b_addr,
   output logic [COORD_BITS-1:0] rd_a_x,
   output logic [COORD_BITS-1:0] rd_a_y,
   output logic [COORD_BITS-1:0] rd_b_x,
   output logic [COORD_BITS-1:0] rd_b_y
);

   logic [2*COORD_BITS-1:0] mem [MAX_PINS];
   logic [2*COORD_BITS-1:0] rd_a_ff, rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_x, wr_y};
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   assign rd_a_x = rd_a_ff[2*COORD_BITS-1:COORD_BITS];
   assign rd_a_y = rd_a_ff[COORD_BITS-1:0];
   assign rd_b_x = rd_b_ff[2*COORD_BITS-1:COORD_BITS];
   assign rd_b_y = rd_b_ff[COORD_BITS-1:0];

endmodule

@@ rtl/prord_best.sv @@
// per pin nearest distance and order position memory
module prord_best import prord_pkg::*; #(
   parameter int MAX_PINS = MAX_PINS_DEF,
   parameter int DIST_W   = COORD_BITS_DEF + 11,
   parameter int AW       = $clog2(MAX_PINS)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DIST_W-1:0] wr_dist,
   input  logic [AW-1:0]     wr_pos,
   input  logic [AW-1:0]     rd_addr,
   output logic [DIST_W-1:0] rd_dist,
   output logic [AW-1:0]     rd_pos
);

   logic [DIST_W+AW-1:0] mem [MAX_PINS];
   logic [DIST_W+AW-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_dist, wr_pos};
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_dist = rd_ff[DIST_W+AW-1:AW];
   assign rd_pos  = rd_ff[AW-1:0];

endmodule

@@ rtl/pin_routing_order_prim_core.sv @@
// pin routing order top level: load, closest pair scan and prim passes
//
// Pins load at one per cycle while busy is low; the pin marked last starts
// ordering and busy stays high until the order is out. For n stored pins the
// closest pair scan runs first, then each of the n order positions takes one
// pass over the coordinate store, which has two read ports and sets the pace.
// One result per pass appears on the rsp_ ports for a single cycle marked by
// rsp_strobe; the receiver cannot hold results off, so it must take every
// strobe.
module pin_routing_order_prim_core import prord_pkg::*; #(
   parameter int MAX_PINS   = MAX_PINS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [PIN_W-1:0]  req_pin_x,
   input  logic [PIN_W-1:0]  req_pin_y,
   input  logic              req_last_pin,
   output logic              rsp_strobe,
   output logic [IDX_W-1:0]  rsp_pin_index,
   output logic [PIN_W-1:0]  rsp_order_x,
   output logic [PIN_W-1:0]  rsp_order_y,
   output logic              rsp_last_out,
   input  logic              csr_write_en,
   input  logic [DIAG_W-1:0] csr_diagonal_cost
);

   localparam int AW     = $clog2(MAX_PINS);
   localparam int CNT_W  = $clog2(MAX_PINS + 1);
   localparam int DIST_W = COORD_BITS + 11;

   state_type state_ff, state_in;

   logic [DIAG_W-1:0] diag_ff;
   logic [CNT_W-1:0]  cnt_ff, n_ff, i_ff, j_ff;
   logic [AW-1:0]     src_ff, pos_ff, pa_ff, pb_ff;
   logic [MAX_PINS-1:0] sel_ff;
   logic              first_ff;

   // pipeline: 1 memory data, 2 distance half, 3 distance ready
   logic              v1_ff, v2_ff, v3_ff;
   logic [AW-1:0]     ia1_ff, ib1_ff, ia2_ff, ib2_ff, ia3_ff, ib3_ff;
   logic [DIST_W-1:0] bd2_ff, bd3_ff;
   logic [AW-1:0]     bp2_ff, bp3_ff;

   logic              pfound_ff, mfound_ff;
   logic [DIST_W-1:0] pbest_ff, md_ff;
   logic [AW-1:0]     mp_ff, midx_ff;

   logic              accept, store_wr, issue_v, pipe_empty, pair_mode, last_pos;
   logic [CNT_W-1:0]  n_load;
   logic [AW-1:0]     rd_a_addr, rd_b_addr;

   logic [COORD_BITS-1:0] a_x, a_y, b_x, b_y;
   logic [DIST_W-1:0]     cur_dist, bd1;
   logic [AW-1:0]         bp1;
   logic [DIST_W-1:0]     nd;
   logic [AW-1:0]         np;
   logic                  best_wr, take;

   assign accept     = start && !busy;
   assign store_wr   = accept && (cnt_ff < CNT_W'(MAX_PINS));
   assign n_load     = store_wr ? cnt_ff + CNT_W'(1) : cnt_ff;
   assign pipe_empty = !v1_ff && !v2_ff && !v3_ff;
   assign pair_mode  = (state_ff == ST_PAIR) || (state_ff == ST_PDRAIN);
   assign last_pos   = (CNT_W'(pos_ff) + CNT_W'(1)) == n_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_last_pin) begin
               state_in = (n_load == CNT_W'(1)) ? ST_EMIT : ST_PAIR;
            end
         end
         ST_PAIR: begin
            if (j_ff == n_ff - CNT_W'(1) && i_ff == n_ff - CNT_W'(2)) begin
               state_in = ST_PDRAIN;
            end
         end
         ST_PDRAIN: begin
            if (pipe_empty) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT:   state_in = ST_RUN;
         ST_RUN: begin
            if (i_ff == n_ff - CNT_W'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (pipe_empty) begin
               state_in = last_pos ? ST_IDLE : ST_EMIT;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      busy      = 1'b1;
      issue_v   = 1'b0;
      rd_a_addr = i_ff[AW-1:0];
      rd_b_addr = src_ff;
      case (state_ff)
         ST_IDLE:  busy = 1'b0;
         ST_PAIR: begin
            issue_v   = 1'b1;
            rd_b_addr = j_ff[AW-1:0];
         end
         ST_RUN:   issue_v = !sel_ff[i_ff[AW-1:0]];
         default:  issue_v = 1'b0;
      endcase
   end

   prord_store #(.MAX_PINS(MAX_PINS), .COORD_BITS(COORD_BITS), .AW(AW)) u_store (
      .clock     (clock),
      .wr_en     (store_wr),
      .wr_addr   (cnt_ff[AW-1:0]),
      .wr_x      (COORD_BITS'(req_pin_x)),
      .wr_y      (COORD_BITS'(req_pin_y)),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_x    (a_x),
      .rd_a_y    (a_y),
      .rd_b_x    (b_x),
      .rd_b_y    (b_y)
   );

   prord_dist #(.COORD_BITS(COORD_BITS), .DIST_W(DIST_W)) u_dist (
      .clock    (clock),
      .a_x      (a_x),
      .a_y      (a_y),
      .b_x      (b_x),
      .b_y      (b_y),
      .diag     (diag_ff),
      .dist_out (cur_dist)
   );

   prord_best #(.MAX_PINS(MAX_PINS), .DIST_W(DIST_W), .AW(AW)) u_best (
      .clock   (clock),
      .wr_en   (best_wr),
      .wr_addr (ia3_ff),
      .wr_dist (nd),
      .wr_pos  (np),
      .rd_addr (i_ff[AW-1:0]),
      .rd_dist (bd1),
      .rd_pos  (bp1)
   );

   // relax step and running minimum for the next pick
   always_comb begin
      if (pos_ff == '0 || cur_dist < bd3_ff) begin
         nd = cur_dist;
         np = pos_ff;
      end else begin
         nd = bd3_ff;
         np = bp3_ff;
      end
      best_wr = v3_ff && !pair_mode;
      take    = !mfound_ff || nd < md_ff || (nd == md_ff && np < mp_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         diag_ff      <= DIAG_RESET;
         cnt_ff       <= '0;
         sel_ff       <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_strobe   <= 1'b0;
         first_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         v1_ff      <= issue_v;
         v2_ff      <= v1_ff;
         v3_ff      <= v2_ff;
         rsp_strobe <= (state_ff == ST_RUN) && first_ff;
         if (csr_write_en) begin
            diag_ff <= csr_diagonal_cost;
         end
         if (accept) begin
            cnt_ff <= req_last_pin ? '0 : n_load;
         end
         case (state_ff)
            ST_EMIT: begin
               first_ff <= 1'b1;
               // the pair partner is marked together with the first pin
               sel_ff   <= sel_ff | (MAX_PINS'(1) << src_ff)
                           | ((pos_ff == '0) ? (MAX_PINS'(1) << pb_ff) : '0);
            end
            ST_RUN:   first_ff <= 1'b0;
            ST_DRAIN: begin
               if (pipe_empty && last_pos) begin
                  sel_ff <= '0;
               end
            end
            default:  first_ff <= 1'b0;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      ia1_ff <= rd_a_addr;
      ib1_ff <= rd_b_addr;
      ia2_ff <= ia1_ff;
      ib2_ff <= ib1_ff;
      ia3_ff <= ia2_ff;
      ib3_ff <= ib2_ff;
      bd2_ff <= bd1;
      bp2_ff <= bp1;
      bd3_ff <= bd2_ff;
      bp3_ff <= bp2_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_last_pin) begin
               n_ff      <= n_load;
               i_ff      <= '0;
               j_ff      <= CNT_W'(1);
               pos_ff    <= '0;
               src_ff    <= '0;
               pb_ff     <= '0;
               pfound_ff <= 1'b0;
            end
         end
         ST_PAIR: begin
            if (j_ff == n_ff - CNT_W'(1)) begin
               i_ff <= i_ff + CNT_W'(1);
               j_ff <= i_ff + CNT_W'(2);
            end else begin
               j_ff <= j_ff + CNT_W'(1);
            end
         end
         ST_PDRAIN: begin
            if (pipe_empty) begin
               src_ff <= pa_ff;
               pb_ff  <= pb_ff;
            end
         end
         ST_EMIT: begin
            i_ff      <= '0;
            mfound_ff <= 1'b0;
         end
         ST_RUN: begin
            i_ff <= i_ff + CNT_W'(1);
         end
         ST_DRAIN: begin
            if (pipe_empty && !last_pos) begin
               pos_ff <= pos_ff + AW'(1);
               src_ff <= (pos_ff == '0) ? pb_ff : midx_ff;
            end
         end
         default: begin
            i_ff <= i_ff;
         end
      endcase
      // closest pair, first strict minimum in scan order
      if (v3_ff && pair_mode && (!pfound_ff || cur_dist < pbest_ff)) begin
         pfound_ff <= 1'b1;
         pbest_ff  <= cur_dist;
         pa_ff     <= ia3_ff;
         pb_ff     <= ib3_ff;
      end
      if (best_wr && take) begin
         mfound_ff <= 1'b1;
         md_ff     <= nd;
         mp_ff     <= np;
         midx_ff   <= ia3_ff;
      end
      if ((state_ff == ST_RUN) && first_ff) begin
         rsp_pin_index <= IDX_W'(src_ff);
         rsp_order_x   <= PIN_W'(b_x);
         rsp_order_y   <= PIN_W'(b_y);
         rsp_last_out  <= last_pos;
      end
   end

`ifndef SYNTHESIS
   // a new pass only starts once the previous pass has written all its bests
   a_emit_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> pipe_empty)
      else $error("pass started with relax writes in flight");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe outside ordering");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two results in consecutive cycles");

   a_no_pick_late: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN && pipe_empty && !last_pos && pos_ff != '0) |-> mfound_ff)
      else $error("no unselected pin found for next position");
`endif

endmodule

@@ tb/testbench.sv @@
// testbench for the pin routing order block: random nets checked against a prim order model
`timescale 1ns / 1ps
module testbench;
   import prord_pkg::*;

   typedef struct packed {
      logic [PIN_W-1:0] x;
      logic [PIN_W-1:0] y;
      logic             last;
   } pin_req_type;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic [PIN_W-1:0] x;
      logic [PIN_W-1:0] y;
      logic             last;
   } order_rsp_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [PIN_W-1:0]  req_pin_x;
   logic [PIN_W-1:0]  req_pin_y;
   logic              req_last_pin;
   logic              rsp_strobe;
   logic [IDX_W-1:0]  rsp_pin_index;
   logic [PIN_W-1:0]  rsp_order_x;
   logic [PIN_W-1:0]  rsp_order_y;
   logic              rsp_last_out;
   logic              csr_write_en;
   logic [DIAG_W-1:0] csr_diagonal_cost;

   pin_routing_order_prim_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_pin_x(req_pin_x), .req_pin_y(req_pin_y), .req_last_pin(req_last_pin),
      .rsp_strobe(rsp_strobe), .rsp_pin_index(rsp_pin_index),
      .rsp_order_x(rsp_order_x), .rsp_order_y(rsp_order_y),
      .rsp_last_out(rsp_last_out),
      .csr_write_en(csr_write_en), .csr_diagonal_cost(csr_diagonal_cost)
   );

   pin_req_type   pending_pins[$];
   order_rsp_type expected_order[$];
   int            error_count = 0;
   int            gap_left = 0;
   bit            req_taken = 1'b0;

   // predictor state
   logic [DIAG_W-1:0] diag_cost = DIAG_RESET;
   logic [PIN_W-1:0]  net_x[MAX_PINS_DEF];
   logic [PIN_W-1:0]  net_y[MAX_PINS_DEF];
   int                net_size = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint octile_dist(int a, int b);
      longint dx, dy, lo, hi;
      dx = net_x[a] > net_x[b] ? net_x[a] - net_x[b] : net_x[b] - net_x[a];
      dy = net_y[a] > net_y[b] ? net_y[a] - net_y[b] : net_y[b] - net_y[a];
      lo = dx < dy ? dx : dy;
      hi = dx < dy ? dy : dx;
      return lo * diag_cost + (hi - lo) * 256;
   endfunction

   function automatic void push_order(int idx, int pos, int n);
      order_rsp_type r;
      r.idx = idx[IDX_W-1:0];
      r.x = net_x[idx];
      r.y = net_y[idx];
      r.last = (pos + 1 == n);
      expected_order.insert(expected_order.size(), r);
   endfunction

   task automatic predict_pin(pin_req_type p);
      int n, a, b, pick;
      longint best, d;
      longint dist_best[MAX_PINS_DEF];
      int     pos_best[MAX_PINS_DEF];
      bit     taken[MAX_PINS_DEF];
      if (net_size < MAX_PINS_DEF) begin
         net_x[net_size] = p.x;
         net_y[net_size] = p.y;
         net_size++;
      end
      if (!p.last) return;
      n = net_size;
      net_size = 0;
      if (n == 0) return;
      if (n == 1) begin
         push_order(0, 0, 1);
         return;
      end
      a = 0; b = 1;
      best = octile_dist(0, 1);
      for (int i = 0; i < n; i++)
         for (int j = i + 1; j < n; j++) begin
            d = octile_dist(i, j);
            if (d < best) begin
               best = d; a = i; b = j;
            end
         end
      for (int i = 0; i < n; i++) taken[i] = 0;
      taken[a] = 1;
      taken[b] = 1;
      push_order(a, 0, n);
      push_order(b, 1, n);
      for (int i = 0; i < n; i++) begin
         dist_best[i] = octile_dist(i, a);
         pos_best[i] = 0;
         d = octile_dist(i, b);
         if (d < dist_best[i]) begin
            dist_best[i] = d; pos_best[i] = 1;
         end
      end
      for (int k = 2; k < n; k++) begin
         pick = -1;
         for (int i = 0; i < n; i++) begin
            if (taken[i]) continue;
            if (pick < 0 || dist_best[i] < dist_best[pick] ||
                (dist_best[i] == dist_best[pick] && pos_best[i] < pos_best[pick]))
               pick = i;
         end
         taken[pick] = 1;
         push_order(pick, k, n);
         for (int i = 0; i < n; i++) begin
            if (taken[i]) continue;
            d = octile_dist(i, pick);
            if (d < dist_best[i]) begin
               dist_best[i] = d; pos_best[i] = k;
            end
         end
      end
   endtask

   function automatic pin_req_type rand_pin(bit last, int span);
      pin_req_type p;
      int bx;
      bx = $urandom_range(4095 - span);
      p.x = PIN_W'(bx + $urandom_range(span));
      p.y = PIN_W'($urandom_range(4095 - span) + $urandom_range(span));
      if ($urandom_range(19) == 0) p.x = PIN_W'($urandom);
      p.last = last;
      return p;
   endfunction

   function automatic void add_net(int n, int span);
      for (int i = 0; i < n; i++)
         pending_pins.insert(pending_pins.size(), rand_pin(i == n - 1, span));
   endfunction

   function automatic void add_pin(int x, int y, bit last);
      pin_req_type p;
      p.x = PIN_W'(x); p.y = PIN_W'(y); p.last = last;
      pending_pins.insert(pending_pins.size(), p);
   endfunction

   // a request is taken when start is high and busy low at a rising edge
   always @(posedge clock) begin
      req_taken <= !reset && start && !busy;
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_pin_x <= '0;
         req_pin_y <= '0;
         req_last_pin <= 1'b0;
      end else if (req_taken) begin
         // request taken at the last rising edge
         predict_pin(pending_pins[0]);
         pending_pins.delete(0);
         if (pending_pins.size() > 0 && $urandom_range(3) != 0) begin
            req_pin_x <= pending_pins[0].x;
            req_pin_y <= pending_pins[0].y;
            req_last_pin <= pending_pins[0].last;
         end else begin
            start <= 1'b0;
            gap_left <= ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(3);
         end
      end else if (!start && pending_pins.size() > 0) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else begin
            start <= 1'b1;
            req_pin_x <= pending_pins[0].x;
            req_pin_y <= pending_pins[0].y;
            req_last_pin <= pending_pins[0].last;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      order_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_order.size() == 0) begin
            $display("%0t: unexpected result idx=%0d x=%0d y=%0d last=%0d", $time,
                     rsp_pin_index, rsp_order_x, rsp_order_y, rsp_last_out);
            error_count++;
         end else begin
            want = expected_order[0];
            expected_order.delete(0);
            if (want.idx !== rsp_pin_index) begin
               $display("%0t: pin_index expected %0d actual %0d", $time, want.idx,
                        rsp_pin_index);
               error_count++;
            end
            if (want.x !== rsp_order_x) begin
               $display("%0t: order_x expected %0d actual %0d", $time, want.x,
                        rsp_order_x);
               error_count++;
            end
            if (want.y !== rsp_order_y) begin
               $display("%0t: order_y expected %0d actual %0d", $time, want.y,
                        rsp_order_y);
               error_count++;
            end
            if (want.last !== rsp_last_out) begin
               $display("%0t: last_out expected %0d actual %0d", $time, want.last,
                        rsp_last_out);
               error_count++;
            end
         end
      end
   end

   task automatic drain_and_settle();
      while (pending_pins.size() > 0 || start || expected_order.size() > 0 || busy)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_diag(int value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_diagonal_cost <= DIAG_W'(value);
      @(negedge clock);
      csr_write_en <= 1'b0;
      diag_cost = DIAG_W'(value);
   endtask

   initial begin
      int n;
      int diag_list[6] = '{362, 256, 1023, 0, 200, 512};
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_diagonal_cost = DIAG_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: single pin, extremes, ties, a lone last with an empty store
      add_pin(4095, 4095, 1);
      add_pin(0, 0, 0);
      add_pin(4095, 4095, 0);
      add_pin(0, 4095, 0);
      add_pin(4095, 0, 1);
      add_pin(10, 10, 0);
      add_pin(11, 11, 0);
      add_pin(10, 11, 0);
      add_pin(11, 10, 0);
      add_pin(10, 10, 1);
      add_pin(2730, 1365, 0);
      add_pin(1365, 2730, 1);
      drain_and_settle();

      // overflow: 66 pins, the extra ones dropped
      add_net(66, 4095);
      drain_and_settle();

      for (int phase = 0; phase < 6; phase++) begin
         write_diag(diag_list[phase]);
         for (int net = 0; net < 10; net++) begin
            n = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
            add_net(n, ($urandom_range(1) == 0) ? 15 : 4095);
         end
         drain_and_settle();
      end

      if (error_count == 0 && expected_order.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #4000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

@@ files.f @@
rtl/prord_pkg.sv
rtl/prord_dist.sv
rtl/prord_store.sv
rtl/prord_best.sv
rtl/pin_routing_order_prim_core.sv
tb/testbench.sv
